// File: design/vrpc_pkg.sv
// ----------------------------------------------------------------------------
// vrpc_pkg
// Shared types, constants and fixed-point helpers for the vertex rotate,
// project and clip block.
// ----------------------------------------------------------------------------
package vrpc_pkg;

	localparam logic signed [23:0] MAX24 = 24'sh7FFFFF;
	localparam logic signed [23:0] MIN24 = 24'sh800000;

	typedef enum logic [2:0] {
		REG_COS_X = 3'd0,
		REG_SIN_X = 3'd1,
		REG_COS_Y = 3'd2,
		REG_SIN_Y = 3'd3,
		REG_COS_Z = 3'd4,
		REG_SIN_Z = 3'd5,
		REG_EYE   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_MUL,
		FE_PUSH
	} fe_state_t;

	typedef enum logic [2:0] {
		BE_IDLE,
		BE_MUL,
		BE_INIT,
		BE_DIV,
		BE_FIN
	} be_state_t;

	typedef struct packed {
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] rz;
		logic signed [23:0] min_z;
		logic        [19:0] tri_num;
		logic               last;
		logic               fend;
	} job_t;

	// round half up after >>14, add offset, saturate to 24 bits
	function automatic logic signed [23:0] rnd_sat(input logic signed [41:0] v,
	                                               input logic signed [25:0] off);
		logic signed [41:0] t;
		logic signed [27:0] s;
		logic signed [28:0] u;
		t = v + 42'sd8192;
		s = t[41:14];
		u = {s[27], s} + {{3{off[25]}}, off};
		if (u > 29'sd8388607)
			return MAX24;
		else if (u < -29'sd8388608)
			return MIN24;
		else
			return u[23:0];
	endfunction

endpackage

// File: design/vrpc_front.sv
// ----------------------------------------------------------------------------
// vrpc_front
// Accepts vertices, rotates them on one shared multiplier, tracks triangle
// bookkeeping and queues projection jobs.
// ----------------------------------------------------------------------------
module vrpc_front #(
	parameter int SCREEN_W      = 1920,
	parameter int SCREEN_H      = 1000,
	parameter int MAX_TRIANGLES = 1048576
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic signed [23:0]   vx,
	input  logic signed [23:0]   vy,
	input  logic signed [23:0]   vz,
	input  logic                 frame_end,
	input  logic signed [15:0]   cos_x,
	input  logic signed [15:0]   sin_x,
	input  logic signed [15:0]   cos_y,
	input  logic signed [15:0]   sin_y,
	input  logic signed [15:0]   cos_z,
	input  logic signed [15:0]   sin_z,
	input  logic                 q_full,
	output logic                 q_push,
	output vrpc_pkg::job_t       q_data
);

	localparam int TW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam logic signed [25:0] OFF_X = 26'((SCREEN_W / 4) * 256);
	localparam logic signed [25:0] OFF_Y = 26'((SCREEN_H / 4) * 256);

	vrpc_pkg::fe_state_t state_q, state_d;
	logic [3:0]          step_q;
	logic signed [23:0]  vx_q, vy_q, vz_q;
	logic                fend_q;
	logic signed [39:0]  prod_q, acc_q;
	logic signed [23:0]  ry_q, rz_q, rx_q, px_q, py_q;
	logic [1:0]          corner_q;
	logic signed [23:0]  min_q;
	logic [TW-1:0]       cnt_q;

	logic signed [23:0]  opa;
	logic signed [15:0]  opb;
	logic                neg;
	logic signed [39:0]  mul;
	logic signed [41:0]  sum;
	logic signed [25:0]  off;
	logic signed [23:0]  rs;
	logic signed [23:0]  base_min, new_min;
	logic                last;
	logic [24:0]         cnt_ext;

	always_comb begin
		opa = vy_q;
		opb = cos_x;
		neg = 1'b0;
		case (step_q)
			4'd0: begin opa = vy_q; opb = cos_x; end
			4'd1: begin opa = vz_q; opb = sin_x; neg = 1'b1; end
			4'd2: begin opa = vy_q; opb = sin_x; end
			4'd3: begin opa = vz_q; opb = cos_x; end
			4'd4: begin opa = vx_q; opb = cos_y; end
			4'd5: begin opa = rz_q; opb = sin_y; end
			4'd6: begin opa = vx_q; opb = sin_y; neg = 1'b1; end
			4'd7: begin opa = rz_q; opb = cos_y; end
			4'd8: begin opa = rx_q; opb = cos_z; end
			4'd9: begin opa = ry_q; opb = sin_z; neg = 1'b1; end
			4'd10: begin opa = rx_q; opb = sin_z; end
			4'd11: begin opa = ry_q; opb = cos_z; end
			default: begin opa = vy_q; opb = cos_x; end
		endcase
		mul = 40'(opa * opb);
		sum = {{2{acc_q[39]}}, acc_q} + {{2{prod_q[39]}}, prod_q};
		case (step_q)
			4'd10:   off = OFF_X;
			4'd12:   off = OFF_Y;
			default: off = 26'sd0;
		endcase
		rs = vrpc_pkg::rnd_sat(sum, off);
	end

	always_comb begin
		base_min = (corner_q == 2'd0) ? vrpc_pkg::MAX24 : min_q;
		new_min  = (rz_q < base_min) ? rz_q : base_min;
		last     = (corner_q == 2'd2);
		cnt_ext  = 25'(cnt_q);
		q_data.px      = px_q;
		q_data.py      = py_q;
		q_data.rz      = rz_q;
		q_data.min_z   = new_min;
		q_data.tri_num = cnt_ext[19:0];
		q_data.last    = last;
		q_data.fend    = fend_q;
	end

	always_comb begin
		state_d = state_q;
		full    = (state_q != vrpc_pkg::FE_IDLE);
		q_push  = 1'b0;
		case (state_q)
			vrpc_pkg::FE_IDLE: begin
				if (push)
					state_d = vrpc_pkg::FE_MUL;
			end
			vrpc_pkg::FE_MUL: begin
				if (step_q == 4'd12)
					state_d = vrpc_pkg::FE_PUSH;
			end
			vrpc_pkg::FE_PUSH: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = vrpc_pkg::FE_IDLE;
				end
			end
			default: state_d = vrpc_pkg::FE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= vrpc_pkg::FE_IDLE;
			step_q   <= 4'd0;
			corner_q <= 2'd0;
			min_q    <= vrpc_pkg::MAX24;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == vrpc_pkg::FE_IDLE)
				step_q <= 4'd0;
			else if (state_q == vrpc_pkg::FE_MUL)
				step_q <= step_q + 4'd1;
			if (q_push) begin
				if (fend_q) begin
					corner_q <= 2'd0;
					min_q    <= vrpc_pkg::MAX24;
					cnt_q    <= '0;
				end else if (last) begin
					corner_q <= 2'd0;
					min_q    <= vrpc_pkg::MAX24;
					if (32'(cnt_q) >= MAX_TRIANGLES - 1)
						cnt_q <= '0;
					else
						cnt_q <= cnt_q + TW'(1);
				end else begin
					corner_q <= corner_q + 2'd1;
					min_q    <= new_min;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == vrpc_pkg::FE_IDLE && push) begin
			vx_q   <= vx;
			vy_q   <= vy;
			vz_q   <= vz;
			fend_q <= frame_end;
		end
		if (state_q == vrpc_pkg::FE_MUL) begin
			prod_q <= neg ? -mul : mul;
			if (step_q[0])
				acc_q <= prod_q;
			case (step_q)
				4'd2:  ry_q <= rs;
				4'd4:  rz_q <= rs;
				4'd6:  rx_q <= rs;
				4'd8:  rz_q <= rs;
				4'd10: px_q <= rs;
				4'd12: py_q <= rs;
				default: ;
			endcase
		end
	end

endmodule

// File: design/vrpc_queue.sv
// ----------------------------------------------------------------------------
// vrpc_queue
// Two-entry job queue between the rotation front and the projection back.
// ----------------------------------------------------------------------------
module vrpc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  vrpc_pkg::job_t wdata,
	output logic           full,
	input  logic           rd,
	output vrpc_pkg::job_t rdata,
	output logic           empty
);

	vrpc_pkg::job_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wp_q <= ~wp_q;
			if (rd)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

endmodule

// File: design/vrpc_back.sv
// ----------------------------------------------------------------------------
// vrpc_back
// Perspective divide, screen offset, clip test and result register.
// ----------------------------------------------------------------------------
module vrpc_back #(
	parameter int SCREEN_W = 1920,
	parameter int SCREEN_H = 1000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  vrpc_pkg::job_t     q_data,
	output logic               q_pop,
	input  logic signed [15:0] eye_depth,
	output logic               empty,
	input  logic               pop,
	output logic signed [23:0] screen_x,
	output logic signed [23:0] screen_y,
	output logic signed [23:0] depth_z,
	output logic               culled,
	output logic signed [23:0] tri_min_depth,
	output logic        [19:0] tri_number,
	output logic               tri_last,
	output logic               frame_last
);

	localparam logic signed [27:0] OFF_X = 28'(400 * 256);
	localparam logic signed [27:0] OFF_Y = 28'((SCREEN_H / 3) * 256);
	localparam logic signed [23:0] XMAX  = 24'((SCREEN_W - 1) * 256);
	localparam logic signed [23:0] YMAX  = 24'((SCREEN_H - 1) * 256);

	vrpc_pkg::be_state_t state_q, state_d;
	vrpc_pkg::job_t      job_q;
	logic signed [24:0]  d_q;
	logic [23:0]         dm_q;
	logic [46:0]         nx_q, ny_q;
	logic                sgx_q, sgy_q, ovx_q, ovy_q;
	logic [23:0]         rx_q, ry_q;
	logic [24:0]         qx_q, qy_q;
	logic [4:0]          bit_q;
	logic                ov_q;

	logic signed [23:0]  eye256;
	logic signed [24:0]  d_new;
	logic                cull0;
	logic signed [39:0]  px_e, py_e;
	logic [39:0]         ax, ay;
	logic [24:0]         tx, ty;
	logic [25:0]         mx, my;
	logic signed [27:0]  vxs, vys;
	logic signed [23:0]  sxo, syo;
	logic                out_free;

	function automatic logic signed [23:0] sat28(input logic signed [27:0] v);
		if (v > 28'sd8388607)
			return vrpc_pkg::MAX24;
		else if (v < -28'sd8388608)
			return vrpc_pkg::MIN24;
		else
			return v[23:0];
	endfunction

	always_comb begin
		eye256 = {eye_depth, 8'h00};
		d_new  = {eye256[23], eye256} - {q_data.rz[23], q_data.rz};
		cull0  = (q_data.min_z < eye256) || (d_new == 25'sd0);
		px_e   = 40'(job_q.px * eye_depth);
		py_e   = 40'(job_q.py * eye_depth);
		ax     = px_e[39] ? 40'(-px_e) : px_e;
		ay     = py_e[39] ? 40'(-py_e) : py_e;
		tx     = {rx_q, nx_q[{1'b0, bit_q}]};
		ty     = {ry_q, ny_q[{1'b0, bit_q}]};
		mx     = ovx_q ? 26'h2000000 : {1'b0, qx_q};
		my     = ovy_q ? 26'h2000000 : {1'b0, qy_q};
		vxs    = (sgx_q ? -{2'b00, mx} : {2'b00, mx}) + OFF_X;
		vys    = (sgy_q ? -{2'b00, my} : {2'b00, my}) + OFF_Y;
		sxo    = sat28(vxs);
		syo    = sat28(vys);
		out_free = empty || pop;
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			vrpc_pkg::BE_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop = 1'b1;
					if (!cull0)
						state_d = vrpc_pkg::BE_MUL;
				end
			end
			vrpc_pkg::BE_MUL:  state_d = vrpc_pkg::BE_INIT;
			vrpc_pkg::BE_INIT: state_d = vrpc_pkg::BE_DIV;
			vrpc_pkg::BE_DIV: begin
				if (bit_q == 5'd0)
					state_d = vrpc_pkg::BE_FIN;
			end
			vrpc_pkg::BE_FIN: begin
				if (out_free)
					state_d = vrpc_pkg::BE_IDLE;
			end
			default: state_d = vrpc_pkg::BE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vrpc_pkg::BE_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == vrpc_pkg::BE_IDLE && q_pop && cull0)
				ov_q <= 1'b1;
			else if (state_q == vrpc_pkg::BE_FIN && out_free)
				ov_q <= 1'b1;
			else if (pop)
				ov_q <= 1'b0;
		end
	end

	assign empty = !ov_q;

	always_ff @(posedge clk) begin
		case (state_q)
			vrpc_pkg::BE_IDLE: begin
				job_q <= q_data;
				d_q   <= d_new;
				if (q_pop && cull0) begin
					screen_x      <= 24'sd0;
					screen_y      <= 24'sd0;
					culled        <= 1'b1;
					depth_z       <= q_data.rz;
					tri_min_depth <= q_data.min_z;
					tri_number    <= q_data.tri_num;
					tri_last      <= q_data.last;
					frame_last    <= q_data.fend;
				end
			end
			vrpc_pkg::BE_MUL: begin
				nx_q  <= {ax[38:0], 8'h00};
				ny_q  <= {ay[38:0], 8'h00};
				sgx_q <= px_e[39] ^ d_q[24];
				sgy_q <= py_e[39] ^ d_q[24];
				dm_q  <= d_q[24] ? 24'(-d_q) : d_q[23:0];
			end
			vrpc_pkg::BE_INIT: begin
				ovx_q <= {2'b00, nx_q[46:25]} >= dm_q;
				ovy_q <= {2'b00, ny_q[46:25]} >= dm_q;
				rx_q  <= {2'b00, nx_q[46:25]};
				ry_q  <= {2'b00, ny_q[46:25]};
				bit_q <= 5'd24;
			end
			vrpc_pkg::BE_DIV: begin
				if (tx >= {1'b0, dm_q}) begin
					rx_q        <= 24'(tx - {1'b0, dm_q});
					qx_q[bit_q] <= 1'b1;
				end else begin
					rx_q        <= tx[23:0];
					qx_q[bit_q] <= 1'b0;
				end
				if (ty >= {1'b0, dm_q}) begin
					ry_q        <= 24'(ty - {1'b0, dm_q});
					qy_q[bit_q] <= 1'b1;
				end else begin
					ry_q        <= ty[23:0];
					qy_q[bit_q] <= 1'b0;
				end
				bit_q <= bit_q - 5'd1;
			end
			vrpc_pkg::BE_FIN: begin
				if (out_free) begin
					screen_x      <= sxo;
					screen_y      <= syo;
					culled        <= (sxo < 24'sd0) || (sxo > XMAX) ||
					                 (syo < 24'sd0) || (syo > YMAX);
					depth_z       <= job_q.rz;
					tri_min_depth <= job_q.min_z;
					tri_number    <= job_q.tri_num;
					tri_last      <= job_q.last;
					frame_last    <= job_q.fend;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: design/vertex_rotate_project_clip.sv
// ----------------------------------------------------------------------------
// vertex_rotate_project_clip
// Rotates vertices about X, Y and Z, projects them to the screen and clips.
//
//   channel  | handshake           | fields
//   ---------+---------------------+------------------------------------------
//   input    | push / full         | vx vy vz frame_end
//   result   | empty / pop         | screen_x screen_y depth_z culled
//            |                     | tri_min_depth tri_number tri_last frame_last
//   config   | wr_en               | wr_index wr_data
//
// Front: one vertex at a time on one shared 24x16 multiplier (12 products).
// Back: one vertex at a time; visible vertices pass the 25-step radix-2
// divider that runs x and y side by side; vertices culled early skip it.
// A two-word queue lets the front run up to two vertices ahead.
// Reset clears control state and loads identity rotation and eye -1100.
// ----------------------------------------------------------------------------
module vertex_rotate_project_clip #(
	parameter int SCREEN_W      = 1920,
	parameter int SCREEN_H      = 1000,
	parameter int MAX_TRIANGLES = 1048576
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [23:0] vx,
	input  logic signed [23:0] vy,
	input  logic signed [23:0] vz,
	input  logic               frame_end,
	output logic               empty,
	input  logic               pop,
	output logic signed [23:0] screen_x,
	output logic signed [23:0] screen_y,
	output logic signed [23:0] depth_z,
	output logic               culled,
	output logic signed [23:0] tri_min_depth,
	output logic        [19:0] tri_number,
	output logic               tri_last,
	output logic               frame_last,
	input  logic               wr_en,
	input  logic        [2:0]  wr_index,
	input  logic        [15:0] wr_data
);

	logic signed [15:0] cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q, eye_q;
	logic               q_full, q_push, q_empty, q_pop;
	vrpc_pkg::job_t     q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_x_q <= 16'sd16384;
			sin_x_q <= 16'sd0;
			cos_y_q <= 16'sd16384;
			sin_y_q <= 16'sd0;
			cos_z_q <= 16'sd16384;
			sin_z_q <= 16'sd0;
			eye_q   <= -16'sd1100;
		end else if (wr_en) begin
			case (vrpc_pkg::reg_idx_t'(wr_index))
				vrpc_pkg::REG_COS_X: cos_x_q <= wr_data;
				vrpc_pkg::REG_SIN_X: sin_x_q <= wr_data;
				vrpc_pkg::REG_COS_Y: cos_y_q <= wr_data;
				vrpc_pkg::REG_SIN_Y: sin_y_q <= wr_data;
				vrpc_pkg::REG_COS_Z: cos_z_q <= wr_data;
				vrpc_pkg::REG_SIN_Z: sin_z_q <= wr_data;
				vrpc_pkg::REG_EYE:   eye_q   <= wr_data;
				default: ;
			endcase
		end
	end

	vrpc_front #(
		.SCREEN_W      (SCREEN_W),
		.SCREEN_H      (SCREEN_H),
		.MAX_TRIANGLES (MAX_TRIANGLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.vx        (vx),
		.vy        (vy),
		.vz        (vz),
		.frame_end (frame_end),
		.cos_x     (cos_x_q),
		.sin_x     (sin_x_q),
		.cos_y     (cos_y_q),
		.sin_y     (sin_y_q),
		.cos_z     (cos_z_q),
		.sin_z     (sin_z_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	vrpc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	vrpc_back #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.eye_depth     (eye_q),
		.empty         (empty),
		.pop           (pop),
		.screen_x      (screen_x),
		.screen_y      (screen_y),
		.depth_z       (depth_z),
		.culled        (culled),
		.tri_min_depth (tri_min_depth),
		.tri_number    (tri_number),
		.tri_last      (tri_last),
		.frame_last    (frame_last)
	);

endmodule
